[hdl/cle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants and types of the cursor line editor: buffer size, key
// codes, sequencer states and the address unit request.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int CAPACITY = 64;
    localparam int CAP_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h4C;
    localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h52;
    localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h42;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_EOL,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [CAP_W-1:0] a;
        logic [CAP_W-1:0] b;
        logic             sub;
    } t_addr_req;

endpackage

[hdl/cursor_line_editor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_core
// Keystroke line editor on a gap buffer held in a single-port RAM; emits the
// finished line one character per transfer at end of line.
//
//  channel  | dir | tdata          | tuser                      | tlast
//  s_axis   | in  | [7:0] key      | -                          | end_of_line
//  m_axis   | out | [7:0] character| [0] has_char [1] overflowed| last
//
//  Insert, backspace and blocked moves complete as the key is accepted; a
//  cursor move reads the RAM, then writes back in ST_MOVE (both through the
//  one RAM port). End of line passes ST_EOL, then ST_READ and ST_LOAD per
//  character (registered RAM read); an empty line returns from ST_EOL to idle.
//  Synchronous active-low reset; the RAM needs no clearing pass.
//  A stalled m_axis holds the readout; the next key waits for the readout.
// ----------------------------------------------------------------------------
module cursor_line_editor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] key
    input  logic       s_axis_tlast,   // end_of_line
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] character
    output logic [1:0] m_axis_tuser,   // [0] has_char, [1] overflowed
    output logic       m_axis_tlast    // last
);

    localparam int CW = cle_pkg::CAP_W;

    cle_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_left, n_left;
    logic [CW-1:0]              r_right, n_right;
    logic                       r_ovf, n_ovf;
    logic                       r_dir, n_dir;
    logic                       r_eol, n_eol;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [CW-1:0]              r_total, n_total;
    logic [CW-1:0]              r_gap, n_gap;
    logic                       r_out_valid, n_out_valid;
    logic [cle_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic                       r_out_has, n_out_has;
    logic                       r_out_ovf, n_out_ovf;
    logic                       r_out_last, n_out_last;

    cle_pkg::t_addr_req         addr_req;
    logic [cle_pkg::ADDR_W-1:0] addr;
    logic                       ram_we, ram_re;
    logic [cle_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

    logic          in_xfer, out_free, move_go, cnt_last, full;
    logic          key_left, key_right, key_back, key_ins;
    logic [CW-1:0] line_total;

    cle_addr u_addr (
        .i_req  (addr_req),
        .o_addr (addr)
    );

    cle_ram #(
        .WIDTH (cle_pkg::CHAR_W),
        .DEPTH (cle_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == cle_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign key_left  = (s_axis_tdata == cle_pkg::KEY_LEFT);
    assign key_right = (s_axis_tdata == cle_pkg::KEY_RIGHT);
    assign key_back  = (s_axis_tdata == cle_pkg::KEY_BACK);
    assign key_ins   = !key_left && !key_right && !key_back;

    assign line_total = r_left + r_right;
    assign full       = (line_total == CW'(cle_pkg::CAPACITY));
    assign move_go    = (key_left && (r_left != '0)) || (key_right && (r_right != '0));
    assign cnt_last   = ((r_cnt + CW'(1)) == r_total);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cle_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (move_go) begin
                        n_state = cle_pkg::ST_MOVE;
                    end else if (s_axis_tlast) begin
                        n_state = cle_pkg::ST_EOL;
                    end
                end
            end
            cle_pkg::ST_MOVE: begin
                n_state = r_eol ? cle_pkg::ST_EOL : cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_EOL: begin
                if (line_total != '0) begin
                    n_state = cle_pkg::ST_READ;
                end else if (out_free) begin
                    n_state = cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_READ: begin
                n_state = cle_pkg::ST_LOAD;
            end
            cle_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_state = cnt_last ? cle_pkg::ST_IDLE : cle_pkg::ST_READ;
                end
            end
            default: begin
                n_state = cle_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_ovf       = r_ovf;
        n_dir       = r_dir;
        n_eol       = r_eol;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_gap       = r_gap;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_has   = r_out_has;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        addr_req    = '{a: r_left, b: '0, sub: 1'b0};
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = s_axis_tdata;
        case (r_state)
            cle_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_eol = s_axis_tlast;
                    if (key_left) begin
                        n_dir    = 1'b1;
                        addr_req = '{a: r_left, b: CW'(1), sub: 1'b1};
                        ram_re   = (r_left != '0);
                    end else if (key_right) begin
                        n_dir    = 1'b0;
                        addr_req = '{a: CW'(cle_pkg::CAPACITY), b: r_right, sub: 1'b1};
                        ram_re   = (r_right != '0);
                    end else if (key_back) begin
                        if (r_left != '0) begin
                            n_left = r_left - CW'(1);
                        end
                    end else if (key_ins) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            n_left = r_left + CW'(1);
                        end
                    end
                end
            end
            cle_pkg::ST_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (r_dir) begin
                    addr_req = '{a: CW'(cle_pkg::CAPACITY - 1), b: r_right, sub: 1'b1};
                    n_left   = r_left - CW'(1);
                    n_right  = r_right + CW'(1);
                end else begin
                    n_left  = r_left + CW'(1);
                    n_right = r_right - CW'(1);
                end
            end
            cle_pkg::ST_EOL: begin
                n_total = line_total;
                n_gap   = CW'(cle_pkg::CAPACITY) - line_total;
                n_cnt   = '0;
                if ((line_total == '0) && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = '0;
                    n_out_has   = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b1;
                    n_ovf       = 1'b0;
                end
            end
            cle_pkg::ST_READ: begin
                ram_re   = 1'b1;
                addr_req = '{a: r_cnt, b: (r_cnt < r_left) ? '0 : r_gap, sub: 1'b0};
            end
            cle_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ram_rdata;
                    n_out_has   = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_out_last  = cnt_last;
                    n_cnt       = r_cnt + CW'(1);
                    if (cnt_last) begin
                        n_left  = '0;
                        n_right = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::ST_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_right     <= n_right;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir      <= n_dir;
        r_eol      <= n_eol;
        r_cnt      <= n_cnt;
        r_total    <= n_total;
        r_gap      <= n_gap;
        r_out_char <= n_out_char;
        r_out_has  <= n_out_has;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = {r_out_ovf, r_out_has};
    assign m_axis_tlast  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_left} + {1'b0, r_right}) <= (CW + 1)'(cle_pkg::CAPACITY))
        else $error("line length exceeds buffer capacity");

    a_clear_after_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cle_pkg::ST_LOAD) && out_free && cnt_last
        |=> (r_left == '0) && (r_right == '0) && !r_ovf)
        else $error("line not cleared after its last character");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("empty-line result not marked last");

    a_full_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && key_ins && full |=> r_ovf)
        else $error("dropped insert did not set overflow");

endmodule

[hdl/cle_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cle_addr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_addr
// Shared address unit: one add/subtract that forms every buffer address
// (cursor side, gap side and readout walk).
// ----------------------------------------------------------------------------
module cle_addr (
    input  cle_pkg::t_addr_req           i_req,
    output logic [cle_pkg::ADDR_W-1:0]   o_addr
);

    logic [cle_pkg::CAP_W-1:0] sum;

    always_comb begin
        if (i_req.sub) begin
            sum = i_req.a - i_req.b;
        end else begin
            sum = i_req.a + i_req.b;
        end
    end

    assign o_addr = sum[cle_pkg::ADDR_W-1:0];

endmodule

[tb/sv/cursor_line_editor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_core_tb
// Self-checking bench for the gap buffer line editor. Keystrokes are queued,
// driven on s_axis with random gaps, and fed to a line model at each accepted
// transfer. Every m_axis transfer is checked against the oldest predicted
// character. Covers moves and backspace at the line ends, empty lines and a
// full buffer with dropped inserts.
// ----------------------------------------------------------------------------
module cursor_line_editor_core_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 150;
    localparam int NUM_KEYS    = 220;

    typedef struct {
        logic [7:0] key;
        logic       eol;
        logic       hold;   // wait for the line readout to drain first
        logic       calm;   // no idling from here on
    } t_keystroke;

    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       ovf;
        logic       last;
    } t_line_char;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] key
    logic       s_axis_tlast  = 1'b0;    // end_of_line
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] character
    logic [1:0] m_axis_tuser;            // [0] has_char, [1] overflowed
    logic       m_axis_tlast;            // last

    cursor_line_editor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // line model
    logic [7:0] line_text [cle_pkg::CAPACITY];
    int         left_cnt   = 0;
    int         right_cnt  = 0;
    logic       ovf_sticky = 1'b0;

    t_keystroke keystrokes [$];
    t_line_char line_chars [$];
    t_keystroke next_key;
    t_line_char want;

    int   n_keys      = 0;
    int   keys_done   = 0;
    int   idle_cycles = 0;
    bit   failed      = 1'b0;
    bit   s_took      = 1'b0;
    bit   m_took      = 1'b0;
    bit   calm_on     = 1'b0;
    bit   hold_next   = 1'b0;
    bit   calm_now    = 1'b0;
    int   tx_gap      = 0;
    int   tx_quiet    = 0;
    int   rx_stall    = 0;
    int   rx_quiet    = 0;

    function automatic void edit_line(logic [7:0] key, logic eol);
        int         total;
        t_line_char c;
        case (key)
            cle_pkg::KEY_LEFT: begin
                if (left_cnt > 0) begin
                    line_text[cle_pkg::CAPACITY - right_cnt - 1] = line_text[left_cnt - 1];
                    left_cnt--;
                    right_cnt++;
                end
            end
            cle_pkg::KEY_RIGHT: begin
                if (right_cnt > 0) begin
                    line_text[left_cnt] = line_text[cle_pkg::CAPACITY - right_cnt];
                    left_cnt++;
                    right_cnt--;
                end
            end
            cle_pkg::KEY_BACK: begin
                if (left_cnt > 0) left_cnt--;
            end
            default: begin
                if (left_cnt + right_cnt >= cle_pkg::CAPACITY) begin
                    ovf_sticky = 1'b1;
                end else begin
                    line_text[left_cnt] = key;
                    left_cnt++;
                end
            end
        endcase
        if (!eol) return;
        total = left_cnt + right_cnt;
        c.ovf = ovf_sticky;
        if (total == 0) begin
            c.ch   = 8'h00;
            c.has  = 1'b0;
            c.last = 1'b1;
            line_chars.push_back(c);
        end
        c.has = 1'b1;
        for (int i = 0; i < left_cnt; i++) begin
            c.ch   = line_text[i];
            c.last = (i + 1 == total);
            line_chars.push_back(c);
        end
        for (int i = 0; i < right_cnt; i++) begin
            c.ch   = line_text[cle_pkg::CAPACITY - right_cnt + i];
            c.last = (left_cnt + i + 1 == total);
            line_chars.push_back(c);
        end
        left_cnt   = 0;
        right_cnt  = 0;
        ovf_sticky = 1'b0;
    endfunction

    function automatic void add_key(logic [7:0] key, logic eol);
        t_keystroke k;
        k.key  = key;
        k.eol  = eol;
        k.hold = hold_next;
        k.calm = calm_now;
        hold_next = 1'b0;
        keystrokes.push_back(k);
        n_keys++;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == cle_pkg::KEY_LEFT || c == cle_pkg::KEY_RIGHT ||
               c == cle_pkg::KEY_BACK);
        return c;
    endfunction

    function automatic logic [7:0] any_key();
        case ($urandom_range(0, 9))
            0, 1:    return cle_pkg::KEY_LEFT;
            2:       return cle_pkg::KEY_RIGHT;
            3:       return cle_pkg::KEY_BACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // s_axis driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_took)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (keystrokes.size() == 0 ||
                         (keystrokes[0].hold && line_chars.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else if (!keystrokes[0].calm && tx_quiet == 0 &&
                         $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end else begin
                next_key = keystrokes.pop_front();
                if (tx_quiet > 0) tx_quiet--;
                else if ($urandom_range(0, 9) == 0) tx_quiet = $urandom_range(10, 40);
                if (next_key.calm) calm_on = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_key.key;
                s_axis_tlast  <= next_key.eol;
            end
        end
    end

    // m_axis backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n || calm_on) begin
            m_axis_tready <= i_rst_n;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_quiet > 0) begin
            rx_quiet--;
            m_axis_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    rx_stall = $urandom_range(0, 14);
                    m_axis_tready <= 1'b0;
                end
                1: begin
                    rx_quiet = $urandom_range(10, 60);
                    m_axis_tready <= 1'b1;
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        s_took = 1'b0;
        m_took = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                s_took = 1'b1;
                edit_line(s_axis_tdata, s_axis_tlast);
                keys_done++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_took = 1'b1;
                if (line_chars.size() == 0) begin
                    $error("unexpected transfer: character %0h", m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    want = line_chars.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        $error("character: expected %0h, got %0h", want.ch, m_axis_tdata);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[0] !== want.has) begin
                        $error("has_char: expected %0b, got %0b", want.has, m_axis_tuser[0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[1] !== want.ovf) begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, m_axis_tuser[1]);
                        failed = 1'b1;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        failed = 1'b1;
                    end
                end
            end
        end
        if (s_took || m_took) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int len;

        // empty lines, backspace and moves at the line ends
        add_key(cle_pkg::KEY_BACK, 1'b1);
        add_key(cle_pkg::KEY_LEFT, 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b1);
        add_key(8'h00, 1'b0);
        add_key(8'hFF, 1'b0);
        add_key(8'h61, 1'b0);
        add_key(cle_pkg::KEY_LEFT, 1'b0);
        add_key(cle_pkg::KEY_LEFT, 1'b0);
        add_key(cle_pkg::KEY_BACK, 1'b0);
        add_key(8'h7F, 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b0);
        add_key(8'h80, 1'b1);
        add_key(8'h01, 1'b1);
        add_key(8'h55, 1'b0);
        add_key(cle_pkg::KEY_LEFT, 1'b0);
        add_key(cle_pkg::KEY_BACK, 1'b0);
        add_key(cle_pkg::KEY_LEFT, 1'b0);
        add_key(8'hAA, 1'b1);

        // full buffer: drops with the cursor inside the line
        hold_next = 1'b1;
        for (int i = 0; i < 50; i++) add_key(text_byte(), 1'b0);
        for (int i = 0; i < 6; i++) add_key(cle_pkg::KEY_LEFT, 1'b0);
        for (int i = 0; i < 16; i++) add_key(text_byte(), 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b0);
        add_key(cle_pkg::KEY_BACK, 1'b0);
        add_key(text_byte(), 1'b0);
        add_key(text_byte(), 1'b0);
        add_key(cle_pkg::KEY_RIGHT, 1'b1);

        // random lines
        hold_next = 1'b1;
        while (n_keys < NUM_KEYS) begin
            if (n_keys > NUM_KEYS - 40) calm_now = 1'b1;
            if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) add_key(any_key(), 1'b0);
            add_key(any_key(), 1'b1);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (keys_done != n_keys || line_chars.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (!failed && line_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
